FILE: rtl/core/nvgr_pkg.sv
// Package: codes, widths and reset constants for the note voice gate/retrigger block.
package nvgr_pkg;

    localparam int PITCH_W  = 24;
    localparam int TIME_W   = 48;
    localparam int COUNT_W  = 16;
    localparam int REQ_W    = 2;
    localparam int MODE_W   = 2;
    localparam int IN_W     = 144;
    localparam int OUT_W    = 56;

    localparam logic [REQ_W-1:0] REQ_PLAY    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SAMPLES = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESET   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RETRIG  = 2'd2;

    // minus 100 volts in s7.16
    localparam logic [PITCH_W-1:0] PITCH_RESET = 24'h9C0000;
    localparam logic [COUNT_W-1:0] GAP_RESET   = 16'd1;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [PITCH_W-1:0] note_pitch;
        logic [TIME_W-1:0]  event_time;
        logic [TIME_W-1:0]  note_end_time;
        logic [COUNT_W-1:0] sample_count;
        logic               clear_gate;
    } req_t;

    typedef struct packed {
        logic               gate_write;
        logic               gate_level;
        logic               cv_write;
        logic [PITCH_W-1:0] cv_value;
        logic [MODE_W-1:0]  voice_mode;
        logic               note_ended;
        logic [PITCH_W-1:0] current_pitch;
    } rsp_t;

endpackage

FILE: rtl/core/note_voice_gate_retrigger_top.sv
// Top level: one sequencer voice with gate, pitch CV and retrigger countdown.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata: request fields, tuser: req_type
//  m_*      out  m_tvalid/m_tready    tdata: result fields
//  cfg_*    in   cfg_valid/cfg_ready  cfg_data: retrigger_gap_samples
//
// Each word passes through the input register and then the result register,
// one word per cycle sustained while m_tready stays high; the voice state is
// compared and updated as the word moves into the result register.
// Reset (rst_n low) clears the voice state and sets the gap register to 1.
// A stalled result holds in the output register; the input register keeps
// accepting as long as the result register frees in the same cycle.
module note_voice_gate_retrigger_top
    import nvgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [23:0] note_pitch, [71:24] event_time, [119:72] note_end_time,
    // [135:120] sample_count, [136] clear_gate, [143:137] zero
    input  logic [IN_W-1:0]   s_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0]  s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [0] gate_write, [1] gate_level, [2] cv_write, [26:3] cv_value,
    // [28:27] voice_mode, [29] note_ended, [53:30] current_pitch, [55:54] zero
    output logic [OUT_W-1:0]  m_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    logic               in_valid_reg;
    req_t               in_reg;
    logic               out_valid_reg;
    rsp_t               out_reg;
    rsp_t               out_next;

    logic [COUNT_W-1:0] gap_cfg_reg;

    logic [MODE_W-1:0]  mode_reg,       mode_next;
    logic [TIME_W-1:0]  end_time_reg,   end_time_next;
    logic               end_valid_reg,  end_valid_next;
    logic [TIME_W-1:0]  last_end_reg,   last_end_next;
    logic               last_valid_reg, last_valid_next;
    logic [PITCH_W-1:0] played_reg,     played_next;
    logic [PITCH_W-1:0] wait_pitch_reg, wait_pitch_next;
    logic [TIME_W-1:0]  wait_end_reg,   wait_end_next;
    logic [COUNT_W-1:0] gap_cnt_reg,    gap_cnt_next;

    logic               advance;
    logic               s_accept;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_reg.current_pitch, out_reg.note_ended, out_reg.voice_mode,
                        out_reg.cv_value, out_reg.cv_write, out_reg.gate_level,
                        out_reg.gate_write};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_cfg_reg <= GAP_RESET;
        end
        else if (cfg_valid)
        begin
            gap_cfg_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_reg.req_type      <= s_tuser;
            in_reg.note_pitch    <= s_tdata[23:0];
            in_reg.event_time    <= s_tdata[71:24];
            in_reg.note_end_time <= s_tdata[119:72];
            in_reg.sample_count  <= s_tdata[135:120];
            in_reg.clear_gate    <= s_tdata[136];
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        end_time_next   = end_time_reg;
        end_valid_next  = end_valid_reg;
        last_end_next   = last_end_reg;
        last_valid_next = last_valid_reg;
        played_next     = played_reg;
        wait_pitch_next = wait_pitch_reg;
        wait_end_next   = wait_end_reg;
        gap_cnt_next    = gap_cnt_reg;

        out_next = '0;

        case (in_reg.req_type)
            REQ_PLAY:
            begin
                out_next.gate_write = 1'b1;
                if (last_valid_reg && (in_reg.event_time == last_end_reg))
                begin
                    // back-to-back note: drop the gate and hold the note
                    mode_next       = MODE_RETRIG;
                    wait_pitch_next = in_reg.note_pitch;
                    wait_end_next   = in_reg.note_end_time;
                    gap_cnt_next    = (gap_cfg_reg != '0) ? gap_cfg_reg : GAP_RESET;
                end
                else
                begin
                    played_next         = in_reg.note_pitch;
                    end_time_next       = in_reg.note_end_time;
                    end_valid_next      = 1'b1;
                    mode_next           = MODE_PLAYING;
                    out_next.cv_write   = 1'b1;
                    out_next.cv_value   = in_reg.note_pitch;
                    out_next.gate_level = 1'b1;
                end
            end
            REQ_ADVANCE:
            begin
                if (end_valid_reg && (end_time_reg <= in_reg.event_time))
                begin
                    out_next.gate_write = 1'b1;
                    out_next.note_ended = 1'b1;
                    last_end_next       = end_time_reg;
                    last_valid_next     = 1'b1;
                    end_valid_next      = 1'b0;
                    end_time_next       = '0;
                    mode_next           = MODE_IDLE;
                end
            end
            REQ_SAMPLES:
            begin
                if (gap_cnt_reg != '0)
                begin
                    if (in_reg.sample_count >= gap_cnt_reg)
                    begin
                        // countdown expired: reopen the gate with the held note
                        gap_cnt_next        = '0;
                        mode_next           = MODE_PLAYING;
                        out_next.cv_write   = 1'b1;
                        out_next.cv_value   = wait_pitch_reg;
                        end_time_next       = wait_end_reg;
                        end_valid_next      = 1'b1;
                        out_next.gate_write = 1'b1;
                        out_next.gate_level = 1'b1;
                    end
                    else
                    begin
                        gap_cnt_next = gap_cnt_reg - in_reg.sample_count;
                    end
                end
            end
            default:
            begin
                mode_next           = MODE_IDLE;
                end_time_next       = '0;
                end_valid_next      = 1'b0;
                last_end_next       = '0;
                last_valid_next     = 1'b0;
                played_next         = PITCH_RESET;
                gap_cnt_next        = '0;
                out_next.gate_write = in_reg.clear_gate;
            end
        endcase

        out_next.voice_mode    = mode_next;
        out_next.current_pitch = played_next;
    end

    // voice state, updated as each word moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            end_time_reg   <= '0;
            end_valid_reg  <= 1'b0;
            last_end_reg   <= '0;
            last_valid_reg <= 1'b0;
            played_reg     <= PITCH_RESET;
            wait_pitch_reg <= '0;
            wait_end_reg   <= '0;
            gap_cnt_reg    <= '0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            end_time_reg   <= end_time_next;
            end_valid_reg  <= end_valid_next;
            last_end_reg   <= last_end_next;
            last_valid_reg <= last_valid_next;
            played_reg     <= played_next;
            wait_pitch_reg <= wait_pitch_next;
            wait_end_reg   <= wait_end_next;
            gap_cnt_reg    <= gap_cnt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    // a CV write always comes with the gate going high
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.cv_write) |-> (out_reg.gate_write && out_reg.gate_level))
    else $error("cv write without gate rising");

    // an ended note leaves the voice idle with the gate dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.note_ended)
        |-> (out_reg.voice_mode == MODE_IDLE && out_reg.gate_write && !out_reg.gate_level))
    else $error("note end without idle mode and gate drop");

    // retrigger mode always has a countdown running
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_RETRIG) |-> (gap_cnt_reg != '0))
    else $error("retrigger mode with empty countdown");

    // a word in the input register moves on whenever the result register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
    else $error("input word not forwarded");
`endif

endmodule

FILE: tb/tb.sv
// Testbench for the note voice gate/retrigger block: directed table then random requests.
`timescale 1ns / 1ps

module tb
    import nvgr_pkg::*;
();

    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 186;
    localparam int LONG_HOLD       = 64;

    typedef struct packed {
        req_t req;
        logic typed;
        rsp_t want;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic [REQ_W-1:0]  s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [COUNT_W-1:0] cfg_data = '0;

    // voice state as seen from outside
    logic [MODE_W-1:0]  mode_q;
    logic [TIME_W-1:0]  pend_end;
    logic               pend_valid;
    logic [TIME_W-1:0]  prev_end;
    logic               prev_valid;
    logic [PITCH_W-1:0] held_pitch;
    logic [PITCH_W-1:0] retrig_pitch;
    logic [TIME_W-1:0]  retrig_end;
    logic [16:0]        gap_left;
    logic [COUNT_W-1:0] gap_setting;

    logic [TIME_W-1:0]  song_time = '0;
    rsp_t               pending_results[$];
    row_t               directed_rows[$];
    int                 fails = 0;
    int                 idle_cycles = 0;
    bit                 burst = 1'b0;

    note_voice_gate_retrigger_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void voice_clear();
        mode_q     = MODE_IDLE;
        pend_end   = '0;
        pend_valid = 1'b0;
        prev_end   = '0;
        prev_valid = 1'b0;
        held_pitch = PITCH_RESET;
        gap_left   = '0;
    endfunction

    function automatic rsp_t mk_rsp(logic gw, logic gl, logic cw, logic [PITCH_W-1:0] cv,
                                    logic [MODE_W-1:0] md, logic ended,
                                    logic [PITCH_W-1:0] cur);
        rsp_t o;
        o.gate_write    = gw;
        o.gate_level    = gl;
        o.cv_write      = cw;
        o.cv_value      = cv;
        o.voice_mode    = md;
        o.note_ended    = ended;
        o.current_pitch = cur;
        return o;
    endfunction

    // Advance the voice by one request and return the word it must produce.
    function automatic rsp_t voice_step(req_t r);
        rsp_t o;
        o = '0;
        case (r.req_type)
            REQ_PLAY: begin
                if (prev_valid && r.event_time == prev_end) begin
                    // back-to-back note: drop the gate and hold pitch/end for the countdown
                    mode_q       = MODE_RETRIG;
                    o.gate_write = 1'b1;
                    retrig_pitch = r.note_pitch;
                    retrig_end   = r.note_end_time;
                    gap_left     = (gap_setting == '0) ? 17'd1 : {1'b0, gap_setting};
                end else begin
                    held_pitch   = r.note_pitch;
                    pend_end     = r.note_end_time;
                    pend_valid   = 1'b1;
                    mode_q       = MODE_PLAYING;
                    o.cv_write   = 1'b1;
                    o.cv_value   = r.note_pitch;
                    o.gate_write = 1'b1;
                    o.gate_level = 1'b1;
                end
            end
            REQ_ADVANCE: begin
                if (pend_valid && pend_end <= r.event_time) begin
                    o.gate_write = 1'b1;
                    o.note_ended = 1'b1;
                    prev_end     = pend_end;
                    prev_valid   = 1'b1;
                    pend_valid   = 1'b0;
                    pend_end     = '0;
                    mode_q       = MODE_IDLE;
                end
            end
            REQ_SAMPLES: begin
                if (gap_left != '0) begin
                    if ({1'b0, r.sample_count} >= gap_left) begin
                        gap_left     = '0;
                        mode_q       = MODE_PLAYING;
                        o.cv_write   = 1'b1;
                        o.cv_value   = retrig_pitch;
                        pend_end     = retrig_end;
                        pend_valid   = 1'b1;
                        o.gate_write = 1'b1;
                        o.gate_level = 1'b1;
                    end else begin
                        gap_left = gap_left - {1'b0, r.sample_count};
                    end
                end
            end
            default: begin
                voice_clear();
                o.gate_write = r.clear_gate;
            end
        endcase
        o.voice_mode    = mode_q;
        o.current_pitch = held_pitch;
        return o;
    endfunction

    function automatic void add_row(logic [REQ_W-1:0] op, logic [PITCH_W-1:0] p,
                                    logic [TIME_W-1:0] et, logic [TIME_W-1:0] ee,
                                    logic [COUNT_W-1:0] sc, logic clr,
                                    logic typed = 1'b0, rsp_t want = '0);
        row_t w;
        w.req.req_type      = op;
        w.req.note_pitch    = p;
        w.req.event_time    = et;
        w.req.note_end_time = ee;
        w.req.sample_count  = sc;
        w.req.clear_gate    = clr;
        w.typed             = typed;
        w.want              = want;
        directed_rows.push_back(w);
    endfunction

    task automatic send_req(input req_t r, input logic typed, input rsp_t want);
        int   idle;
        rsp_t predicted;
        if ($urandom_range(0, 39) == 0)
            burst = ~burst;
        idle = burst ? 0 : $urandom_range(0, 3);
        if (idle > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r.clear_gate, r.sample_count, r.note_end_time, r.event_time,
                     r.note_pitch};
        s_tuser  <= r.req_type;
        do @(posedge clk); while (!s_tready);
        predicted = voice_step(r);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic gen_req(output req_t r);
        int unsigned    pick;
        int unsigned    n;
        logic [63:0]    w;
        logic [TIME_W-1:0] dur;
        pick = $urandom_range(0, 99);
        w = rand64();
        r.note_pitch = w[23:0];
        r.sample_count = w[39:24];
        r.clear_gate = w[40];
        w = rand64();
        r.event_time = w[47:0];
        w = rand64();
        r.note_end_time = w[47:0];
        dur = {16'd0, $urandom_range(1, 32'h30000)};
        if (pick < 30)
        begin
            r.req_type = REQ_PLAY;
            if ($urandom_range(0, 7) != 0)
            begin
                // mostly chain notes so retriggers happen often
                if (prev_valid && $urandom_range(0, 3) != 0)
                    r.event_time = prev_end;
                else
                    r.event_time = song_time;
                r.note_end_time = r.event_time + dur;
                song_time = r.note_end_time;
            end
        end
        else if (pick < 60)
        begin
            r.req_type = REQ_ADVANCE;
            if (pend_valid && $urandom_range(0, 3) != 0)
                r.event_time = pend_end + {46'd0, 2'($urandom_range(0, 2))};
            else if ($urandom_range(0, 1) == 1)
                r.event_time = song_time - {16'd0, $urandom_range(0, 32'h10000)};
        end
        else if (pick < 93)
        begin
            r.req_type = REQ_SAMPLES;
            if (gap_left != '0)
            begin
                case ($urandom_range(0, 2))
                    0: r.sample_count = gap_left[15:0];
                    1:
                    begin
                        n = $urandom_range(0, gap_left);
                        r.sample_count = n[15:0];
                    end
                    default: ;
                endcase
            end
        end
        else
        begin
            r.req_type = REQ_RESET;
        end
    endtask

    task automatic write_gap(input logic [COUNT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        gap_setting = v;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic cmp(input string what, input logic [47:0] want, input logic [47:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
            fails++;
        end
    endtask

    initial
    begin : stimulus
        req_t               r;
        logic [COUNT_W-1:0] gap_plan [5];
        logic [63:0]        w;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        voice_clear();
        retrig_pitch = '0;
        retrig_end   = '0;
        gap_setting  = GAP_RESET;
        @(posedge clk);
        write_gap(GAP_RESET);

        // idle voice: advance and samples change nothing, reset may drop the gate
        add_row(REQ_ADVANCE, 24'h0, 48'hFFFF_FFFF_FFFF, 48'h0, 16'h0, 1'b1,
                1'b1, mk_rsp(1'b0, 1'b0, 1'b0, '0, MODE_IDLE, 1'b0, PITCH_RESET));
        add_row(REQ_SAMPLES, 24'hFFFFFF, 48'h0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0,
                1'b1, mk_rsp(1'b0, 1'b0, 1'b0, '0, MODE_IDLE, 1'b0, PITCH_RESET));
        add_row(REQ_RESET, 24'h0, 48'h0, 48'h0, 16'h0, 1'b1,
                1'b1, mk_rsp(1'b1, 1'b0, 1'b0, '0, MODE_IDLE, 1'b0, PITCH_RESET));
        add_row(REQ_PLAY, 24'h7FFFFF, 48'h0, 48'h1_0000, 16'h0, 1'b0,
                1'b1, mk_rsp(1'b1, 1'b1, 1'b1, 24'h7FFFFF, MODE_PLAYING, 1'b0, 24'h7FFFFF));
        add_row(REQ_ADVANCE, 24'h0, 48'hFFFF, 48'h0, 16'h0, 1'b0);
        add_row(REQ_ADVANCE, 24'h0, 48'h1_0000, 48'h0, 16'h0, 1'b0);
        // back-to-back note keeps the old played pitch
        add_row(REQ_PLAY, 24'h800000, 48'h1_0000, 48'hFFFF_FFFF_FFFF, 16'h0, 1'b1);
        add_row(REQ_SAMPLES, 24'h0, 48'h0, 48'h0, 16'h0, 1'b0);
        add_row(REQ_SAMPLES, 24'h0, 48'h0, 48'h0, 16'h1, 1'b0);
        add_row(REQ_ADVANCE, 24'h0, 48'hFFFF_FFFF_FFFF, 48'h0, 16'h0, 1'b0);
        add_row(REQ_PLAY, 24'h000001, 48'hFFFF_FFFF_FFFF, 48'h2_0000, 16'h0, 1'b0);
        add_row(REQ_RESET, 24'h0, 48'h0, 48'h0, 16'h0, 1'b0);
        add_row(REQ_SAMPLES, 24'h0, 48'h0, 48'h0, 16'h5, 1'b0);
        add_row(REQ_PLAY, 24'h000000, 48'hFFFF_FFFF_FFFF, 48'h3_0000, 16'h0, 1'b0);
        add_row(REQ_ADVANCE, 24'h0, 48'h3_0000, 48'h0, 16'h0, 1'b0);
        add_row(REQ_PLAY, 24'hFFFFFF, 48'h2_0000, 48'h5_0000, 16'h0, 1'b0);
        add_row(REQ_ADVANCE, 24'h0, 48'h5_0000, 48'h0, 16'h0, 1'b0);
        add_row(REQ_PLAY, 24'h123456, 48'h5_0000, 48'h6_0000, 16'h0, 1'b0);
        // retrigger while a note is still pending, then end that note mid-countdown
        add_row(REQ_PLAY, 24'h654321, 48'h0, 48'h7_0000, 16'h0, 1'b0);
        add_row(REQ_PLAY, 24'h0ABCDE, 48'h5_0000, 48'h8_0000, 16'h0, 1'b0);
        add_row(REQ_ADVANCE, 24'h0, 48'h7_0000, 48'h0, 16'h0, 1'b0);
        add_row(REQ_SAMPLES, 24'h0, 48'h0, 48'h0, 16'h1, 1'b0);
        add_row(REQ_RESET, 24'h0, 48'h0, 48'h0, 16'h0, 1'b1);

        foreach (directed_rows[i])
            send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        drain();

        w = rand64();
        gap_plan[0] = 16'd0;
        gap_plan[1] = 16'hFFFF;
        gap_plan[2] = 16'd3;
        gap_plan[3] = w[15:0] | 16'd4;
        gap_plan[4] = 16'd1;
        foreach (gap_plan[p])
        begin
            write_gap(gap_plan[p]);
            repeat (ITEMS_PER_PHASE)
            begin
                gen_req(r);
                send_req(r, 1'b0, '0);
            end
            drain();
        end

        repeat (4) @(posedge clk);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : sink
        int          hold;
        int          words_seen;
        rsp_t        want;
        logic [OUT_W-1:0] got;
        words_seen = 0;
        @(posedge rst_n);
        forever
        begin
            // long hold-off so the block fills up and stalls its input
            if (words_seen == 150 || words_seen == 600)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            hold = burst ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got = m_tdata;
            words_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word expected none, actual %0h", $time, got);
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                cmp("gate_write", 48'(want.gate_write), 48'(got[0]));
                cmp("gate_level", 48'(want.gate_level), 48'(got[1]));
                cmp("cv_write", 48'(want.cv_write), 48'(got[2]));
                cmp("cv_value", 48'(want.cv_value), 48'(got[26:3]));
                cmp("voice_mode", 48'(want.voice_mode), 48'(got[28:27]));
                cmp("note_ended", 48'(want.note_ended), 48'(got[29]));
                cmp("current_pitch", 48'(want.current_pitch), 48'(got[53:30]));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
